// ===== hw/rtl/mcr_pkg.sv =====
// Shared types and constants of the midpoint circle rasteriser.
`default_nettype none
package mcr_pkg;

  localparam int unsigned CellW      = 7;
  localparam int unsigned HeightW    = 15;
  localparam int unsigned IndexW     = 8;
  localparam int unsigned CxW        = 15;
  localparam int unsigned CyW        = 16;
  localparam int unsigned OffW       = 5;
  localparam int unsigned RadW       = 5;
  localparam int unsigned StepXW     = 6;
  localparam int unsigned StepYW     = 7;
  localparam int unsigned DecW       = 8;
  localparam int unsigned MathW      = 10;
  localparam int unsigned MaxRadius  = 31;
  localparam int unsigned MaxResults = 48;
  localparam int unsigned PhaseLimit = MaxResults / 2;
  localparam int unsigned CountW     = $clog2(PhaseLimit);

  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  localparam logic RegCellSize     = 1'b0;
  localparam logic RegScreenHeight = 1'b1;

  localparam int unsigned CellSizeReset     = 32;
  localparam int unsigned ScreenHeightReset = 800;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_RUN
  } mcr_state_e;

  typedef struct packed {
    logic load;
    logic calc;
    logic step;
    logic next_phase;
  } mcr_cmd_t;

  typedef struct packed {
    logic out_free;
    logic phase_end;
    logic phase;
  } mcr_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mcr_ctrl.sv =====
// Sequencing state machine of the midpoint circle rasteriser.
`default_nettype none
module mcr_ctrl
  import mcr_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  mcr_status_t status_i,
  output mcr_cmd_t    cmd_o
);

  mcr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.out_free && status_i.phase_end && status_i.phase) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o       = 1'b1;
    cmd_o            = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
      end
      ST_RUN: begin
        cmd_o.step       = status_i.out_free;
        cmd_o.next_phase = status_i.out_free && status_i.phase_end && !status_i.phase;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mcr_dp.sv =====
// Datapath of the midpoint circle rasteriser: centre, iteration and output register.
`default_nettype none
module mcr_dp
  import mcr_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  mcr_cmd_t                 cmd_i,
  output mcr_status_t              status_o,
  input  wire  [CellW-1:0]         cell_size_i,
  input  wire  [HeightW-1:0]       screen_height_i,
  input  wire  [IndexW-1:0]        cell_col_i,
  input  wire  [IndexW-1:0]        cell_row_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output logic [CxW-1:0]           center_x_o,
  output logic signed [CyW-1:0]    center_y_o,
  output logic [OffW-1:0]          offset_x_o,
  output logic [OffW-1:0]          offset_y_o,
  output logic                     fill_phase_o,
  output logic                     last_of_run_o
);

  localparam int unsigned ProdW = IndexW + CellW;

  logic [IndexW-1:0]        col_q, row_q;
  logic [CxW-1:0]           cx_q;
  logic signed [CyW-1:0]    cy_q;
  logic [RadW-1:0]          rad_q;
  logic [StepXW-1:0]        x_q, x_d;
  logic signed [StepYW-1:0] y_q, y_d;
  logic signed [DecW-1:0]   d_q, d_d;
  logic                     phase_q;
  logic [CountW-1:0]        n_q;
  logic                     out_valid_q;

  logic [ProdW-1:0]         col_prod, row_prod;
  logic [CellW-2:0]         half;
  logic [RadW-1:0]          rad_c;
  logic [ProdW-1:0]         cx_c, row_off;
  logic signed [CyW-1:0]    cy_c;

  logic signed [MathW-1:0]  dx, dy, dd, dr, dn;
  logic [StepXW-1:0]        xn;
  logic signed [StepYW-1:0] yn;
  logic                     phase_end;
  logic                     out_free;

  // Centre and radius, worked out once per cell.
  always_comb begin
    col_prod = ProdW'(col_q) * ProdW'(cell_size_i);
    row_prod = ProdW'(row_q) * ProdW'(cell_size_i);
    half     = cell_size_i[CellW-1:1];
    cx_c     = col_prod + ProdW'(half);
    row_off  = row_prod + ProdW'(half);
    cy_c     = CyW'(screen_height_i) - CyW'(row_off);
    if ({1'b0, cell_size_i[CellW-1:2]} > (RadW + 1)'(MaxRadius)) begin
      rad_c = RadW'(MaxRadius);
    end else begin
      rad_c = cell_size_i[CellW-1:2];
    end
  end

  // One midpoint step.
  always_comb begin
    dx = MathW'(x_q);
    dy = MathW'(y_q);
    dd = MathW'(d_q);
    dr = MathW'(rad_q);
    xn = x_q;
    yn = y_q;
    if (dd >= (dx <<< 1)) begin
      dn = dd - (dx <<< 1) - MathW'(1);
      xn = x_q + StepXW'(1);
    end else if (dd < ((dr - dy) <<< 1)) begin
      dn = dd + (dy <<< 1) - MathW'(1);
      yn = y_q - StepYW'(1);
    end else begin
      dn = dd + ((dy - dx - MathW'(1)) <<< 1);
      yn = y_q - StepYW'(1);
      xn = x_q + StepXW'(1);
    end
    phase_end = (MathW'(yn) < $signed(MathW'(xn))) || (n_q == CountW'(PhaseLimit - 1));
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    status_o.out_free  = out_free;
    status_o.phase_end = phase_end;
    status_o.phase     = phase_q;
  end

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    d_d = d_q;
    if (cmd_i.calc) begin
      x_d = '0;
      y_d = StepYW'(rad_c);
      d_d = DecW'(rad_c) - DecW'(1);
    end else if (cmd_i.next_phase) begin
      x_d = '0;
      y_d = StepYW'(rad_q);
      d_d = DecW'(rad_q) - DecW'(1);
    end else if (cmd_i.step) begin
      x_d = xn;
      y_d = yn;
      d_d = dn[DecW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      y_q         <= '0;
      d_q         <= '0;
      phase_q     <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
      d_q <= d_d;
      if (cmd_i.calc) begin
        phase_q <= 1'b0;
        n_q     <= '0;
      end else if (cmd_i.next_phase) begin
        phase_q <= 1'b1;
        n_q     <= '0;
      end else if (cmd_i.step) begin
        if (phase_end) begin
          phase_q <= 1'b0;
          n_q     <= '0;
        end else begin
          n_q <= n_q + CountW'(1);
        end
      end
      if (cmd_i.step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q <= cell_col_i;
      row_q <= cell_row_i;
    end
    if (cmd_i.calc) begin
      cx_q  <= cx_c[CxW-1:0];
      cy_q  <= cy_c;
      rad_q <= rad_c;
    end
    if (cmd_i.step) begin
      center_x_o    <= cx_q;
      center_y_o    <= cy_q;
      offset_x_o    <= x_q[OffW-1:0];
      offset_y_o    <= y_q[OffW-1:0];
      fill_phase_o  <= phase_q;
      last_of_run_o <= phase_q && phase_end;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/midpoint_circle_rasterizer_unit.sv =====
// Top level of the midpoint circle rasteriser: register port, controller and datapath.
`default_nettype none
// Usage. The input channel (in_valid_i / in_stall_o) carries one word per maze
// cell: its column and row index. For every cell the block places a circle of
// radius cell_size/4 at the cell centre, with the row flipped against
// screen_height, and walks the midpoint circle iteration twice, first for the
// outline and then for the fill. Each iteration gives one output word
// (out_valid_o / out_stall_i) with the centre, the octant offsets and the
// phase; the final word of a cell carries last_of_run_o.
// Timing. When an input word is accepted its indices are captured, then the
// centre and radius are worked out, and then the step unit writes the first
// word of the cell to its output register. After that the shared step unit
// gives one word a cycle while out_stall_i does not hold it, at most 48 words
// per cell (radius 31 gives 24 words per phase). A new cell is taken once
// the previous one has issued its last word, even if that word still waits
// in the output register.
// Stalls. While out_stall_i holds a word, the step unit waits and the word
// stays unchanged. Reset empties the output register, returns the controller
// to idle and loads cell_size with 32 and screen_height with 800.
module midpoint_circle_rasterizer_unit
  import mcr_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // APB-style register port
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire  [ApbAddrW-1:0]      paddr,
  input  wire  [ApbDataW-1:0]      pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready,
  // cell input
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire  [IndexW-1:0]        cell_col_i,
  input  wire  [IndexW-1:0]        cell_row_i,
  // result output
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output logic [CxW-1:0]           center_x_o,
  output logic signed [CyW-1:0]    center_y_o,
  output logic [OffW-1:0]          offset_x_o,
  output logic [OffW-1:0]          offset_y_o,
  output logic                     fill_phase_o,
  output logic                     last_of_run_o
);

  logic [CellW-1:0]   cell_size_q;
  logic [HeightW-1:0] screen_height_q;
  logic               reg_sel;
  logic               wr_en;
  mcr_cmd_t           cmd;
  mcr_status_t        status;

  // Register index is the word address; writes to other addresses are ignored
  // beyond that decode.
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q     <= CellW'(CellSizeReset);
      screen_height_q <= HeightW'(ScreenHeightReset);
    end else if (wr_en) begin
      unique case (reg_sel)
        RegCellSize:     cell_size_q     <= pwdata[CellW-1:0];
        RegScreenHeight: screen_height_q <= pwdata[HeightW-1:0];
        default:         cell_size_q     <= cell_size_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegCellSize:     prdata = ApbDataW'(cell_size_q);
      RegScreenHeight: prdata = ApbDataW'(screen_height_q);
      default:         prdata = '0;
    endcase
  end

  mcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mcr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cell_size_i     (cell_size_q),
    .screen_height_i (screen_height_q),
    .cell_col_i      (cell_col_i),
    .cell_row_i      (cell_row_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .center_x_o      (center_x_o),
    .center_y_o      (center_y_o),
    .offset_x_o      (offset_x_o),
    .offset_y_o      (offset_y_o),
    .fill_phase_o    (fill_phase_o),
    .last_of_run_o   (last_of_run_o)
  );

`ifndef NO_ASSERTIONS
  // Once a cell is taken, the input stalls straight after it, so no second cell enters back to back.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("cell accepted while the previous one was still starting");

  // Every emitted point lies in the octant above the diagonal.
  a_octant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (offset_y_o >= offset_x_o))
    else $error("offset_y below offset_x on an emitted word");

  // The closing word of a cell always belongs to the fill pass.
  a_last_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_run_o) |-> fill_phase_o)
    else $error("last_of_run raised during the outline pass");
`endif

endmodule
`default_nettype wire
